// ===== design/tfna_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the tetrahedron face normal and area pipeline.
package tfna_pkg;

	localparam int AREA_BITS = 49;
	localparam int NORM_FRAC = 30;
	localparam int NORM_BITS = 32;
	localparam int ROOT_BITS = NORM_FRAC + 1;
	localparam int QUOT_BITS = 2 * NORM_FRAC + 1;
	localparam int LANES = 3;

	typedef struct packed {
		logic             deg;
		logic [LANES-1:0] neg;
	} side_t;

endpackage

// ===== design/tetra_face_normal_area_core.sv =====
`timescale 1ns / 1ps
// Top level of the tetrahedron face area and outward unit normal pipeline.
// Takes one face word per cycle while the output does not stall and returns one
// result word per face, in order. A face passes through the front arithmetic (8
// stages: edges, cross product, split squares, dot product with the apex edge),
// the 61-stage restoring divider that forms each squared component over the
// squared length, the 31-stage square root of that quotient, and the output
// register; the 49-stage area root runs alongside and is delayed to match.
// A stall on the output freezes the whole pipeline.
module tetra_face_normal_area_core import tfna_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] face_a_x,
	input  logic signed [COORD_BITS-1:0] face_a_y,
	input  logic signed [COORD_BITS-1:0] face_a_z,
	input  logic signed [COORD_BITS-1:0] face_b_x,
	input  logic signed [COORD_BITS-1:0] face_b_y,
	input  logic signed [COORD_BITS-1:0] face_b_z,
	input  logic signed [COORD_BITS-1:0] face_c_x,
	input  logic signed [COORD_BITS-1:0] face_c_y,
	input  logic signed [COORD_BITS-1:0] face_c_z,
	input  logic signed [COORD_BITS-1:0] apex_x,
	input  logic signed [COORD_BITS-1:0] apex_y,
	input  logic signed [COORD_BITS-1:0] apex_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [AREA_BITS-1:0]         area,
	output logic signed [NORM_BITS-1:0]  normal_x,
	output logic signed [NORM_BITS-1:0]  normal_y,
	output logic signed [NORM_BITS-1:0]  normal_z,
	output logic                         degenerate
);

	localparam int SQW      = 4 * COORD_BITS + 2;
	localparam int SW       = 4 * COORD_BITS + 4;
	localparam int VW       = SW - 2;
	localparam int NRM_LAT  = QUOT_BITS + ROOT_BITS;
	localparam int AREA_DLY = NRM_LAT - AREA_BITS;
	localparam logic signed [NORM_BITS-1:0] NORM_ONE = NORM_BITS'(1) << NORM_FRAC;

	logic                         en;
	logic signed [COORD_BITS-1:0] va [LANES];
	logic signed [COORD_BITS-1:0] vb [LANES];
	logic signed [COORD_BITS-1:0] vc [LANES];
	logic signed [COORD_BITS-1:0] vp [LANES];

	logic                 f_vld;
	logic [SQW-1:0]       f_sq [LANES];
	logic [SW-1:0]        f_s2;
	side_t                f_side;
	logic                 d_vld;
	logic [QUOT_BITS-1:0] d_quot [LANES];
	logic                 n_vld [LANES];
	logic [ROOT_BITS-1:0] n_root [LANES];
	logic                 a_vld;
	logic [AREA_BITS-1:0] a_root;
	logic                 ad_vld;
	logic [AREA_BITS-1:0] ad_root;
	logic                 sd_vld;
	side_t                sd_side;
	logic signed [NORM_BITS-1:0] nrm_val [LANES];

	assign en       = !out_valid || !out_stall;
	assign in_stall = out_valid && out_stall;

	assign va[0] = face_a_x;
	assign va[1] = face_a_y;
	assign va[2] = face_a_z;
	assign vb[0] = face_b_x;
	assign vb[1] = face_b_y;
	assign vb[2] = face_b_z;
	assign vc[0] = face_c_x;
	assign vc[1] = face_c_y;
	assign vc[2] = face_c_z;
	assign vp[0] = apex_x;
	assign vp[1] = apex_y;
	assign vp[2] = apex_z;

	tfna_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.a      (va),
		.b      (vb),
		.c      (vc),
		.p      (vp),
		.out_vld(f_vld),
		.sq     (f_sq),
		.s2     (f_s2),
		.side   (f_side)
	);

	tfna_div #(
		.NUM_BITS(SQW),
		.DEN_BITS(SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (f_vld),
		.num    (f_sq),
		.den    (f_s2),
		.out_vld(d_vld),
		.quot   (d_quot)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_nrm
		tfna_isqrt #(
			.VAL_BITS(QUOT_BITS),
			.ROOT_W  (ROOT_BITS)
		) u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (d_vld),
			.val    (d_quot[k]),
			.out_vld(n_vld[k]),
			.root   (n_root[k])
		);
	end

	tfna_isqrt #(
		.VAL_BITS(VW),
		.ROOT_W  (AREA_BITS)
	) u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (f_vld),
		.val    (f_s2[SW-1:2]),
		.out_vld(a_vld),
		.root   (a_root)
	);

	tfna_delay #(
		.WIDTH(AREA_BITS),
		.DEPTH(AREA_DLY)
	) u_area_dly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (a_vld),
		.in_data (a_root),
		.out_vld (ad_vld),
		.out_data(ad_root)
	);

	tfna_delay #(
		.WIDTH($bits(side_t)),
		.DEPTH(NRM_LAT)
	) u_side_dly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (f_vld),
		.in_data (f_side),
		.out_vld (sd_vld),
		.out_data(sd_side)
	);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			nrm_val[k] = sd_side.neg[k] ? -$signed({1'b0, n_root[k]})
				: $signed({1'b0, n_root[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= n_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate <= sd_side.deg;
			area       <= sd_side.deg ? '0 : ad_root;
			normal_x   <= sd_side.deg ? '0 : nrm_val[0];
			normal_y   <= sd_side.deg ? '0 : nrm_val[1];
			normal_z   <= sd_side.deg ? '0 : nrm_val[2];
		end
	end

	a_lanes_aligned : assert property (@(posedge clk) disable iff (!arst_n)
		ad_vld == n_vld[0] && sd_vld == n_vld[0] && n_vld[1] == n_vld[0]
		&& n_vld[2] == n_vld[0])
		else $error("result lanes out of step");

	a_degenerate_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
		area == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate word carries nonzero fields");

	a_normal_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		normal_x <= NORM_ONE && normal_x >= -NORM_ONE
		&& normal_y <= NORM_ONE && normal_y >= -NORM_ONE
		&& normal_z <= NORM_ONE && normal_z >= -NORM_ONE)
		else $error("normal component beyond unit length");

	a_stall_only_full : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held while output free");

endmodule

// ===== design/tfna_delay.sv =====
`timescale 1ns / 1ps
// Enabled delay line that carries a word and its valid bit.
module tfna_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_vld,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] data_s [1:DEPTH];
	logic             vld_s  [1:DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_tap
		logic [WIDTH-1:0] cur_data;
		logic             cur_vld;

		if (i == 0) begin : g_first
			assign cur_data = in_data;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_data = data_s[i];
			assign cur_vld  = vld_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				data_s[i+1] <= cur_data;
			end
		end
	end

	assign out_vld  = vld_s[DEPTH];
	assign out_data = data_s[DEPTH];

endmodule

// ===== design/tfna_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, saturating at all ones.
module tfna_isqrt #(
	parameter int VAL_BITS = 61,
	parameter int ROOT_W   = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [VAL_BITS-1:0] val,
	output logic                out_vld,
	output logic [ROOT_W-1:0]   root
);

	localparam int TW = ((VAL_BITS > 2 * ROOT_W) ? VAL_BITS : 2 * ROOT_W) + 1;

	logic [VAL_BITS-1:0] rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic                vld_s  [1:ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int B = ROOT_W - 1 - i;
		logic [VAL_BITS-1:0] cur_rem;
		logic [ROOT_W-1:0]   cur_root;
		logic                cur_vld;
		logic [TW-1:0]       trial;
		logic                take;

		if (i == 0) begin : g_first
			assign cur_rem  = val;
			assign cur_root = '0;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_vld  = vld_s[i];
		end

		assign trial = (TW'(cur_root) << (B + 1)) | (TW'(1) << (2 * B));
		assign take  = TW'(cur_rem) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? cur_rem - trial[VAL_BITS-1:0] : cur_rem;
				root_s[i+1] <= take ? cur_root | (ROOT_W'(1) << B) : cur_root;
			end
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root    = root_s[ROOT_W];

endmodule

// ===== design/tfna_div.sv =====
`timescale 1ns / 1ps
// Three-lane restoring divider of squared components by the squared length.
module tfna_div import tfna_pkg::*; #(
	parameter int NUM_BITS = 98,
	parameter int DEN_BITS = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [NUM_BITS-1:0]  num [LANES],
	input  logic [DEN_BITS-1:0]  den,
	output logic                 out_vld,
	output logic [QUOT_BITS-1:0] quot [LANES]
);

	logic [DEN_BITS-1:0]  rem_s  [1:QUOT_BITS][LANES];
	logic [QUOT_BITS-1:0] quot_s [1:QUOT_BITS][LANES];
	logic [DEN_BITS-1:0]  den_s  [1:QUOT_BITS];
	logic                 vld_s  [1:QUOT_BITS];

	for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
		logic [DEN_BITS-1:0] cur_den;
		logic                cur_vld;

		if (i == 0) begin : g_first
			assign cur_den = den;
			assign cur_vld = in_vld;
		end else begin : g_next
			assign cur_den = den_s[i];
			assign cur_vld = vld_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= cur_den;
			end
		end

		for (genvar j = 0; j < LANES; j++) begin : g_lane
			logic [DEN_BITS:0]    cand;
			logic [DEN_BITS:0]    diff;
			logic [QUOT_BITS-1:0] cur_q;
			logic                 take;

			if (i == 0) begin : g_first
				assign cand  = (DEN_BITS + 1)'(num[j]);
				assign cur_q = '0;
			end else begin : g_next
				assign cand  = {rem_s[i][j], 1'b0};
				assign cur_q = quot_s[i][j];
			end

			assign diff = cand - {1'b0, cur_den};
			assign take = cand >= {1'b0, cur_den};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1][j]  <= take ? diff[DEN_BITS-1:0] : cand[DEN_BITS-1:0];
					quot_s[i+1][j] <= {cur_q[QUOT_BITS-2:0], take};
				end
			end
		end
	end

	assign out_vld = vld_s[QUOT_BITS];
	for (genvar j = 0; j < LANES; j++) begin : g_out
		assign quot[j] = quot_s[QUOT_BITS][j];
	end

endmodule

// ===== design/tfna_front.sv =====
`timescale 1ns / 1ps
// Front pipeline: edges, cross product, squared length and outward side test.
module tfna_front import tfna_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic signed [COORD_BITS-1:0] a [LANES],
	input  logic signed [COORD_BITS-1:0] b [LANES],
	input  logic signed [COORD_BITS-1:0] c [LANES],
	input  logic signed [COORD_BITS-1:0] p [LANES],
	output logic                        out_vld,
	output logic [4*COORD_BITS+1:0]     sq [LANES],
	output logic [4*COORD_BITS+3:0]     s2,
	output side_t                       side
);

	localparam int EW  = COORD_BITS + 1;
	localparam int XW  = 2 * COORD_BITS + 2;
	localparam int MW  = 2 * COORD_BITS + 1;
	localparam int KX  = COORD_BITS + 1;
	localparam int DHW = (XW - KX) + EW;
	localparam int DLW = KX + 1 + EW;
	localparam int K2  = (MW + 1) / 2;
	localparam int HH  = MW - K2;
	localparam int HHW = 2 * HH;
	localparam int HLW = HH + K2;
	localparam int LLW = 2 * K2;
	localparam int SQW = 2 * MW;
	localparam int SW  = SQW + 2;
	localparam int DTW = 3 * COORD_BITS + 4;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic signed [EW-1:0]  e1_s1 [LANES];
	logic signed [EW-1:0]  e2_s1 [LANES];
	logic signed [EW-1:0]  e3_s1 [LANES];
	logic signed [XW-1:0]  pr_s2 [2*LANES];
	logic signed [EW-1:0]  e3_s2 [LANES];
	logic signed [XW-1:0]  x_s3  [LANES];
	logic signed [EW-1:0]  e3_s3 [LANES];
	logic [MW-1:0]         mag_s4 [LANES];
	logic signed [DHW-1:0] dh_s4 [LANES];
	logic signed [DLW-1:0] dl_s4 [LANES];
	logic [LANES-1:0]      xneg_s4, xneg_s5, xneg_s6, xneg_s7;
	logic [HHW-1:0]        hh_s5 [LANES];
	logic [HLW-1:0]        hl_s5 [LANES];
	logic [LLW-1:0]        ll_s5 [LANES];
	logic signed [DTW-1:0] dot_s5 [LANES];
	logic [SQW-1:0]        sq_s6 [LANES];
	logic signed [DTW-1:0] dsum_s6;
	logic [SQW-1:0]        sq_s7 [LANES];
	logic [SW-1:0]         s2_s7;
	logic                  flip_s7;
	logic [SQW-1:0]        sq_s8 [LANES];
	logic [SW-1:0]         s2_s8;
	side_t                 side_s8;
	logic signed [XW-1:0]  xabs [LANES];

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			xabs[k] = x_s3[k][XW-1] ? -x_s3[k] : x_s3[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				e1_s1[k] <= EW'(b[k]) - EW'(a[k]);
				e2_s1[k] <= EW'(c[k]) - EW'(a[k]);
				e3_s1[k] <= EW'(p[k]) - EW'(a[k]);
			end

			pr_s2[0] <= XW'(e1_s1[1]) * XW'(e2_s1[2]);
			pr_s2[1] <= XW'(e1_s1[2]) * XW'(e2_s1[1]);
			pr_s2[2] <= XW'(e1_s1[2]) * XW'(e2_s1[0]);
			pr_s2[3] <= XW'(e1_s1[0]) * XW'(e2_s1[2]);
			pr_s2[4] <= XW'(e1_s1[0]) * XW'(e2_s1[1]);
			pr_s2[5] <= XW'(e1_s1[1]) * XW'(e2_s1[0]);
			e3_s2    <= e3_s1;

			for (int k = 0; k < LANES; k++) begin
				x_s3[k] <= pr_s2[2*k] - pr_s2[2*k+1];
			end
			e3_s3 <= e3_s2;

			for (int k = 0; k < LANES; k++) begin
				mag_s4[k]  <= xabs[k][MW-1:0];
				xneg_s4[k] <= x_s3[k][XW-1];
				dh_s4[k]   <= DHW'($signed(x_s3[k][XW-1:KX])) * DHW'(e3_s3[k]);
				dl_s4[k]   <= DLW'($signed({1'b0, x_s3[k][KX-1:0]})) * DLW'(e3_s3[k]);
			end

			for (int k = 0; k < LANES; k++) begin
				hh_s5[k]  <= HHW'(mag_s4[k][MW-1:K2]) * HHW'(mag_s4[k][MW-1:K2]);
				hl_s5[k]  <= HLW'(mag_s4[k][MW-1:K2]) * HLW'(mag_s4[k][K2-1:0]);
				ll_s5[k]  <= LLW'(mag_s4[k][K2-1:0]) * LLW'(mag_s4[k][K2-1:0]);
				dot_s5[k] <= (DTW'(dh_s4[k]) <<< KX) + DTW'(dl_s4[k]);
			end
			xneg_s5 <= xneg_s4;

			for (int k = 0; k < LANES; k++) begin
				sq_s6[k] <= (SQW'(hh_s5[k]) << (2 * K2)) + (SQW'(hl_s5[k]) << (K2 + 1))
					+ SQW'(ll_s5[k]);
			end
			dsum_s6 <= dot_s5[0] + dot_s5[1] + dot_s5[2];
			xneg_s6 <= xneg_s5;

			s2_s7   <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			flip_s7 <= !dsum_s6[DTW-1] && (dsum_s6 != '0);
			sq_s7   <= sq_s6;
			xneg_s7 <= xneg_s6;

			s2_s8        <= s2_s7;
			sq_s8        <= sq_s7;
			side_s8.deg  <= (s2_s7 == '0);
			side_s8.neg  <= xneg_s7 ^ {LANES{flip_s7}};
		end
	end

	assign out_vld = vld_s8;
	assign sq      = sq_s8;
	assign s2      = s2_s8;
	assign side    = side_s8;

endmodule

// ===== tb/tb_tetra_face_normal_area_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: face area and outward unit normal against an exact bit-level predictor.
module tb_tetra_face_normal_area_core;
	import tfna_pkg::*;

	localparam int CB = 24;
	localparam int N_RANDOM = 1400;
	localparam int LATENCY = 101;
	localparam int LONG_HOLD = 400;

	typedef logic signed [CB-1:0] crd_t;
	typedef struct {
		crd_t v[12];
	} face_t;
	typedef struct {
		logic [AREA_BITS-1:0]        area;
		logic signed [NORM_BITS-1:0] n[3];
		logic                        deg;
	} geom_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	crd_t face_v[12];
	logic out_valid;
	logic out_stall = 1'b0;
	logic [AREA_BITS-1:0] area;
	logic signed [NORM_BITS-1:0] normal_x, normal_y, normal_z;
	logic degenerate;

	face_t pending_faces[$];
	geom_t expected_geom[$];
	face_t driven_face;
	int errors = 0;
	int faces_sent = 0;
	int results_seen = 0;
	bit in_took = 0;
	bit out_took = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit drained = 0;
	bit long_done = 0;
	bit calm = 0;

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < 12; i++) face_v[i] = '0;
	end

	tetra_face_normal_area_core #(.COORD_BITS(CB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.face_a_x(face_v[0]), .face_a_y(face_v[1]), .face_a_z(face_v[2]),
		.face_b_x(face_v[3]), .face_b_y(face_v[4]), .face_b_z(face_v[5]),
		.face_c_x(face_v[6]), .face_c_y(face_v[7]), .face_c_z(face_v[8]),
		.apex_x(face_v[9]), .apex_y(face_v[10]), .apex_z(face_v[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.area(area), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	function automatic geom_t face_geometry(face_t f);
		logic signed [63:0] e1[3], e2[3], e3[3], x[3];
		logic [63:0] mag[3];
		logic signed [127:0] dot;
		logic [255:0] s2, q4, tt, num;
		logic [63:0] ar, q, t;
		logic flip, neg;
		geom_t r;
		for (int k = 0; k < 3; k++) begin
			e1[k] = $signed(f.v[3+k]) - $signed(f.v[k]);
			e2[k] = $signed(f.v[6+k]) - $signed(f.v[k]);
			e3[k] = $signed(f.v[9+k]) - $signed(f.v[k]);
		end
		x[0] = e1[1] * e2[2] - e1[2] * e2[1];
		x[1] = e1[2] * e2[0] - e1[0] * e2[2];
		x[2] = e1[0] * e2[1] - e1[1] * e2[0];
		s2 = '0;
		dot = '0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = x[k] < 0 ? -x[k] : x[k];
			s2 = s2 + {192'b0, mag[k]} * {192'b0, mag[k]};
			dot = dot + 128'(x[k]) * 128'(e3[k]);
		end
		r.area = '0;
		r.deg = 1'b0;
		for (int k = 0; k < 3; k++) r.n[k] = '0;
		if (s2 == 0) begin
			r.deg = 1'b1;
			return r;
		end
		q4 = s2 >> 2;
		ar = '0;
		for (int b = AREA_BITS - 1; b >= 0; b--) begin
			t = ar | (64'd1 << b);
			tt = {192'b0, t} * {192'b0, t};
			if (tt <= q4) ar = t;
		end
		r.area = ar[AREA_BITS-1:0];
		flip = dot > 0;
		for (int k = 0; k < 3; k++) begin
			num = ({192'b0, mag[k]} * {192'b0, mag[k]}) << (2 * NORM_FRAC);
			q = '0;
			for (int b = NORM_FRAC; b >= 0; b--) begin
				t = q | (64'd1 << b);
				tt = {192'b0, t} * {192'b0, t};
				if (tt * s2 <= num) q = t;
			end
			neg = (x[k] < 0) != flip;
			r.n[k] = neg ? -q[NORM_BITS-1:0] : q[NORM_BITS-1:0];
		end
		return r;
	endfunction

	function automatic crd_t rand_coord(int mode);
		if (mode == 0) return crd_t'($urandom);
		if (mode == 1) return crd_t'($urandom_range(2000) - 1000);
		return crd_t'($urandom_range(3) == 0 ? 24'h800000 : 24'h7fffff);
	endfunction

	function automatic face_t mk(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz, int px, int py, int pz);
		face_t f;
		int a[12];
		a = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
		for (int i = 0; i < 12; i++) f.v[i] = crd_t'(a[i]);
		return f;
	endfunction

	function automatic face_t random_face();
		face_t f;
		int mode, kind;
		logic signed [7:0] s;
		mode = $urandom_range(2);
		kind = $urandom_range(9);
		for (int i = 0; i < 12; i++) f.v[i] = rand_coord(mode);
		if (kind == 0) begin
			s = $urandom_range(6) - 3;
			for (int k = 0; k < 3; k++) f.v[6+k] = f.v[k] + s * (f.v[3+k] - f.v[k]);
		end else if (kind == 1) begin
			for (int k = 0; k < 3; k++) f.v[9+k] = f.v[k];
		end else if (kind == 2) begin
			f.v[2] = f.v[5];
			f.v[8] = f.v[5];
		end
		return f;
	endfunction

	function automatic void queue_face(face_t f);
		pending_faces = {pending_faces, f};
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		out_took = arst_n && out_valid && !out_stall;
		if (in_took) expected_geom = {expected_geom, face_geometry(driven_face)};
		if (out_took) begin
			results_seen++;
			if (expected_geom.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				geom_t w;
				w = expected_geom.pop_front();
				if (area !== w.area) report_mismatch("area", area, w.area);
				if (normal_x !== w.n[0]) report_mismatch("normal_x", normal_x, w.n[0]);
				if (normal_y !== w.n[1]) report_mismatch("normal_y", normal_y, w.n[1]);
				if (normal_z !== w.n[2]) report_mismatch("normal_z", normal_z, w.n[2]);
				if (degenerate !== w.deg) report_mismatch("degenerate", degenerate, w.deg);
			end
		end
	end

	always @(negedge clk) begin
		logic nv;
		face_t f;
		nv = in_valid;
		if (arst_n && !(in_valid && !in_took)) begin
			nv = 1'b0;
			if (faces_sent == 700 && !drained) begin
				if (expected_geom.size() == 0) drained = 1;
			end else if (send_gap > 0) begin
				send_gap--;
			end else if (pending_faces.size() > 0) begin
				f = pending_faces.pop_front();
				driven_face = f;
				for (int i = 0; i < 12; i++) face_v[i] <= f.v[i];
				nv = 1'b1;
				faces_sent++;
				if (faces_sent % 150 == 0) calm = !calm;
				send_gap = calm ? 0 : $urandom_range(10);
			end
		end
		in_valid <= nv;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if (results_seen >= 300 && !long_done) begin
					recv_gap = LONG_HOLD;
					long_done = 1;
				end else begin
					recv_gap = calm ? 0 : $urandom_range(10);
				end
			end
			out_stall <= recv_gap > 0;
			if (recv_gap > 0) recv_gap--;
		end
	end

	initial begin
		queue_face(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_face(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
		queue_face(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, -65536));
		queue_face(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 7, 9, 0));
		queue_face(mk(0, 0, 0, 1, 0, 0, 2, 0, 0, 5, 5, 5));
		queue_face(mk(-8388608, -8388608, -8388608, 8388607, -8388608, 8388607,
			-8388608, 8388607, 8388607, 8388607, 8388607, -8388608));
		queue_face(mk(8388607, 8388607, 8388607, -8388608, 8388607, -8388608,
			8388607, -8388608, -8388608, -8388608, -8388608, 8388607));
		queue_face(mk(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
			-8388608, 8388607, -8388608, 0, 0, 8388607));
		queue_face(mk(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1));
		queue_face(mk(0, 0, 0, 0, 0, 1, 0, 1, 0, 1, 0, 0));
		queue_face(mk(0, 0, 0, 3, 4, 0, 0, 0, 7, -1, 1, 1));
		queue_face(mk(1, 1, 1, 1, 1, 1, 5, 6, 7, 0, 0, 0));
		queue_face(mk(-1, -1, -1, 1, 1, 1, 3, 3, 3, 2, 0, 0));
		queue_face(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
		for (int i = 0; i < N_RANDOM; i++) queue_face(random_face());
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_faces.size() > 0 || in_valid || expected_geom.size() > 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("PASS tetra_face_normal_area_core");
		end else begin
			$display("FAIL tetra_face_normal_area_core");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL tetra_face_normal_area_core");
		$finish;
	end

endmodule

// ===== tetra_face_normal_area_core.f =====
design/tfna_pkg.sv
design/tfna_delay.sv
design/tfna_isqrt.sv
design/tfna_div.sv
design/tfna_front.sv
design/tetra_face_normal_area_core.sv
tb/tb_tetra_face_normal_area_core.sv
